### rtl/ulcdf_pkg.sv
// Shared constants, types and the UTF-8 encoder function of the debug print FIFO.
`timescale 1ns / 1ps

package ulcdf_pkg;

  // Ring buffer geometry.
  localparam int unsigned BUF_BYTES = 1024;
  localparam int unsigned ADDR_W    = $clog2(BUF_BYTES);
  localparam int unsigned CNT_W     = ADDR_W + 1;

  // Fixed field widths of the channels.
  localparam int unsigned CP_W    = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AVAIL_W = 11;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  // One finished result as handed from the sequencer to the output register.
  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic [AVAIL_W-1:0] available_count;
    logic               line_dropping;
  } rsp_t;

  // Encoded character: up to four bytes, first byte in element 0.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [2:0]             len;
  } enc_t;

  // UTF-8 encoding; surrogates and values beyond the code space become U+FFFD.
  function automatic enc_t encode(input logic [CP_W-1:0] cp);
    enc_t        e;
    logic [20:0] c;
    if (cp > 32'h0010_FFFF || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF)) begin
      c = 21'h00FFFD;
    end else begin
      c = cp[20:0];
    end
    e.bytes = '0;
    if (c < 21'h80) begin
      e.bytes[0] = {1'b0, c[6:0]};
      e.len      = 3'd1;
    end else if (c < 21'h800) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.len      = 3'd2;
    end else if (c < 21'h10000) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

### rtl/ulcdf_req_if.sv
// Request channel: request code and codepoint with a valid/ready handshake.
`timescale 1ns / 1ps

interface ulcdf_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [ulcdf_pkg::CP_W-1:0]   codepoint;

  modport source (output valid, output req_type, output codepoint, input ready);
  modport sink   (input valid, input req_type, input codepoint, output ready);
endinterface

### rtl/ulcdf_rsp_if.sv
// Result channel: popped byte and FIFO status with a valid/ready handshake.
`timescale 1ns / 1ps

interface ulcdf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ulcdf_pkg::BYTE_W-1:0]  read_data;
  logic                          read_valid;
  logic [ulcdf_pkg::AVAIL_W-1:0] available_count;
  logic                          line_dropping;

  modport source (output valid, output read_data, output read_valid,
                  output available_count, output line_dropping, input ready);
  modport sink   (input valid, input read_data, input read_valid,
                  input available_count, input line_dropping, output ready);
endinterface

### rtl/utf8_line_committed_debug_fifo_top.sv
// Top level of the line-committed UTF-8 debug print FIFO.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | req_type[1:0], codepoint[31:0]
//   rsp     | out | valid/ready  | read_data[7:0], read_valid, available_count[10:0],
//           |     |              | line_dropping
//
// One request is in work at a time. A write is accepted, stores its UTF-8 bytes one by
// one through the single RAM write port, then hands off; a dropped or rolled-back write,
// or a flush that appends nothing, goes straight to the hand-off, and so does anything
// else but a read. A read waits out the registered RAM read unless nothing is committed.
// Reset clears pointers and counts at once; the byte store needs no clearing. The result
// register takes a new result while the old one leaves, so a stalled rsp side holds the
// sequencer only after one result is waiting.
`timescale 1ns / 1ps

module utf8_line_committed_debug_fifo_top (
  input logic         clk,
  input logic         rst,
  ulcdf_req_if.sink   req,
  ulcdf_rsp_if.source rsp
);
  import ulcdf_pkg::*;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;
  rsp_t              res;
  logic              res_valid;
  logic              slot_free;
  rsp_t              out_q;
  logic              out_valid;

  ulcdf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .res        (res),
    .res_valid  (res_valid),
    .slot_free  (slot_free)
  );

  ulcdf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // The output slot is free when empty or when its result leaves this cycle.
  assign slot_free = !out_valid || rsp.ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.read_data       = out_q.read_data;
  assign rsp.read_valid      = out_q.read_valid;
  assign rsp.available_count = out_q.available_count;
  assign rsp.line_dropping   = out_q.line_dropping;

endmodule

### rtl/ulcdf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module ulcdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/ulcdf_ctrl.sv
// Request sequencer: ring pointers, line commit and rollback, byte writes and reads.
`timescale 1ns / 1ps

module ulcdf_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  ulcdf_req_if.sink                    req,
  output logic                         ram_wr_en,
  output logic [ulcdf_pkg::ADDR_W-1:0] ram_wr_addr,
  output logic [ulcdf_pkg::BYTE_W-1:0] ram_wr_data,
  output logic [ulcdf_pkg::ADDR_W-1:0] ram_rd_addr,
  input  logic [ulcdf_pkg::BYTE_W-1:0] ram_rd_data,
  output ulcdf_pkg::rsp_t              res,
  output logic                         res_valid,
  input  logic                         slot_free
);
  import ulcdf_pkg::*;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]      read_ptr;
  logic [CNT_W-1:0]       stored;
  logic [CNT_W-1:0]       committed;
  logic                   overflow;
  logic [3:0][BYTE_W-1:0] bytes;
  logic [2:0]             len;
  logic [1:0]             idx;
  logic                   commit_line;
  logic [BYTE_W-1:0]      data;
  logic                   data_valid;

  enc_t             enc;
  req_t             code;
  logic             accept;
  logic [2:0]       need;
  logic [CNT_W:0]   room_sum;
  logic             fits;
  logic [CNT_W-1:0] wr_sum;
  logic             last_byte;
  logic [CNT_W-1:0] stored_inc;

  assign code   = req_t'(req.req_type);
  assign enc    = encode(req.codepoint);
  assign accept = req.valid && req.ready;

  // Room check for the bytes a write or a flush would append.
  assign need     = (code == REQ_WRITE) ? enc.len : 3'd1;
  assign room_sum = {1'b0, stored} + (CNT_W + 1)'(need);
  assign fits     = room_sum <= (CNT_W + 1)'(BUF_BYTES);

  // Append position wraps around the ring.
  assign wr_sum      = CNT_W'(read_ptr) + stored;
  assign ram_wr_addr = (wr_sum >= CNT_W'(BUF_BYTES)) ? ADDR_W'(wr_sum - CNT_W'(BUF_BYTES))
                                                     : ADDR_W'(wr_sum);
  assign ram_wr_data = bytes[idx];
  assign ram_rd_addr = read_ptr;
  assign last_byte   = idx == 2'(len - 3'd1);
  assign stored_inc  = stored + CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (code)
            REQ_WRITE, REQ_FLUSH: state_next = (!overflow && fits) ? ST_WRITE : ST_DONE;
            REQ_READ:             state_next = (committed != '0) ? ST_READ : ST_DONE;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        if (last_byte) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    req.ready           = 1'b0;
    ram_wr_en           = 1'b0;
    res_valid           = 1'b0;
    res.read_data       = data;
    res.read_valid      = data_valid;
    res.available_count = AVAIL_W'(committed);
    res.line_dropping   = overflow;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_WRITE: ram_wr_en = 1'b1;
      ST_READ:  ;
      ST_DONE:  res_valid = 1'b1;
      default:  ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      stored    <= '0;
      committed <= '0;
      overflow  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (code)
              REQ_WRITE: begin
                if (!overflow && !fits) begin
                  stored   <= committed;
                  overflow <= 1'b1;
                end
              end
              REQ_FLUSH: begin
                if (!overflow && !fits) begin
                  stored <= committed;
                end
                overflow <= 1'b0;
              end
              REQ_READ: begin
                if (committed != '0) begin
                  read_ptr  <= (read_ptr == ADDR_W'(BUF_BYTES - 1)) ? '0
                                                                    : read_ptr + ADDR_W'(1);
                  stored    <= stored - CNT_W'(1);
                  committed <= committed - CNT_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        ST_WRITE: begin
          stored <= stored_inc;
          if (last_byte && commit_line) begin
            committed <= stored_inc;
          end
        end
        ST_READ, ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Byte staging and read result.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx         <= '0;
          data        <= '0;
          data_valid  <= 1'b0;
          commit_line <= code == REQ_FLUSH;
          if (code == REQ_FLUSH) begin
            bytes <= {{(3 * BYTE_W){1'b0}}, NEWLINE_BYTE};
            len   <= 3'd1;
          end else begin
            bytes <= enc.bytes;
            len   <= enc.len;
          end
        end
      end
      ST_WRITE: idx <= idx + 2'd1;
      ST_READ: begin
        data       <= ram_rd_data;
        data_valid <= 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule
